// ===== hdl/tdoa_pkg.sv =====
// Shared constants and register index codes for the range difference block.
`timescale 1ns / 1ps

package tdoa_pkg;

   localparam int SCALE_WIDTH = 18;
   localparam int FRAC_SHIFT  = 16;
   localparam int TIME_WIDTH  = 28;
   localparam int DIFF_WIDTH  = 29;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [SCALE_WIDTH-1:0] NS_PER_METER_RESET = 18'd218604;
   localparam logic [SCALE_WIDTH-1:0] NS_PER_FOOT_RESET  = 18'd66631;
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX           = {TIME_WIDTH{1'b1}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_EMITTER_X     = 3'd0,
      CSR_EMITTER_Y     = 3'd1,
      CSR_UNITS_IN_FEET = 3'd2,
      CSR_NS_PER_METER  = 3'd3,
      CSR_NS_PER_FOOT   = 3'd4
   } csr_index_type;

endpackage

// ===== hdl/tdoa_square.sv =====
// Magnitude, square and sum-of-squares pipeline stages.
`timescale 1ns / 1ps

module tdoa_square #(
   parameter int POSITION_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [POSITION_WIDTH-1:0]     emitter_x,
   input  logic [POSITION_WIDTH-1:0]     emitter_y,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [POSITION_WIDTH-1:0]     in_x,
   input  logic [POSITION_WIDTH-1:0]     in_y,
   input  logic                          in_ref,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [2*POSITION_WIDTH+1:0]   out_sum,
   output logic [POSITION_WIDTH-1:0]     out_x,
   output logic [POSITION_WIDTH-1:0]     out_y,
   output logic                          out_ref
);

   localparam int PW = POSITION_WIDTH;
   localparam int SW = 2 * PW + 2;
   localparam int NS = 3;

   logic [NS-1:0]    valid_ff;
   logic [NS:0]      ready;
   logic [PW-1:0]    x_ff   [NS];
   logic [PW-1:0]    y_ff   [NS];
   logic [NS-1:0]    ref_ff;

   logic [PW-1:0]    ax_ff, ay_ff, ax_in, ay_in;
   logic [2*PW-1:0]  sx_ff, sy_ff;
   logic [SW-1:0]    sum_ff;
   logic signed [PW:0] dx, dy;

   always_comb begin
      ready[NS] = !out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      dx    = $signed({emitter_x[PW-1], emitter_x}) - $signed({in_x[PW-1], in_x});
      dy    = $signed({emitter_y[PW-1], emitter_y}) - $signed({in_y[PW-1], in_y});
      ax_in = dx[PW] ? PW'(-dx) : PW'(dx);
      ay_in = dy[PW] ? PW'(-dy) : PW'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         x_ff[0]   <= in_x;
         y_ff[0]   <= in_y;
         ref_ff[0] <= in_ref;
      end
      if (ready[1]) begin
         sx_ff     <= ax_ff * ax_ff;
         sy_ff     <= ay_ff * ay_ff;
         x_ff[1]   <= x_ff[0];
         y_ff[1]   <= y_ff[0];
         ref_ff[1] <= ref_ff[0];
      end
      if (ready[2]) begin
         sum_ff    <= SW'(sx_ff) + SW'(sy_ff);
         x_ff[2]   <= x_ff[1];
         y_ff[2]   <= y_ff[1];
         ref_ff[2] <= ref_ff[1];
      end
   end

   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[NS-1];
   assign out_sum   = sum_ff;
   assign out_x     = x_ff[NS-1];
   assign out_y     = y_ff[NS-1];
   assign out_ref   = ref_ff[NS-1];

endmodule

// ===== hdl/tdoa_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module tdoa_sqrt #(
   parameter int POSITION_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [2*POSITION_WIDTH+1:0]   in_sum,
   input  logic [POSITION_WIDTH-1:0]     in_x,
   input  logic [POSITION_WIDTH-1:0]     in_y,
   input  logic                          in_ref,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [POSITION_WIDTH:0]       out_root,
   output logic [POSITION_WIDTH-1:0]     out_x,
   output logic [POSITION_WIDTH-1:0]     out_y,
   output logic                          out_ref
);

   localparam int PW = POSITION_WIDTH;
   localparam int SW = 2 * PW + 2;
   localparam int RW = PW + 1;
   localparam int MW = RW + 2;
   localparam int NS = SW / 2;

   logic [NS-1:0]  valid_ff;
   logic [NS:0]    ready;
   logic [SW-1:0]  rad_ff  [NS];
   logic [RW-1:0]  root_ff [NS];
   logic [MW-1:0]  rem_ff  [NS];
   logic [PW-1:0]  x_ff    [NS];
   logic [PW-1:0]  y_ff    [NS];
   logic [NS-1:0]  ref_ff;

   always_comb begin
      ready[NS] = !out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [SW-1:0]   src_rad;
      logic [RW-1:0]   src_root;
      logic [MW-1:0]   src_rem;
      logic [PW-1:0]   src_x, src_y;
      logic            src_ref, src_valid;
      logic [MW+1:0]   rem_sh, trial;
      logic            take;
      logic [MW-1:0]   rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign src_rad   = in_sum;
         assign src_root  = '0;
         assign src_rem   = '0;
         assign src_x     = in_x;
         assign src_y     = in_y;
         assign src_ref   = in_ref;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src_rad   = rad_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_x     = x_ff[k-1];
         assign src_y     = y_ff[k-1];
         assign src_ref   = ref_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      always_comb begin
         rem_sh  = {src_rem, src_rad[SW-1 -: 2]};
         trial   = (MW + 2)'({src_root, 2'b01});
         take    = rem_sh >= trial;
         rem_in  = take ? MW'(rem_sh - trial) : MW'(rem_sh);
         root_in = {src_root[RW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            rad_ff[k]  <= src_rad << 2;
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            x_ff[k]    <= src_x;
            y_ff[k]    <= src_y;
            ref_ff[k]  <= src_ref;
         end
      end
   end

   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_x     = x_ff[NS-1];
   assign out_y     = y_ff[NS-1];
   assign out_ref   = ref_ff[NS-1];

endmodule

// ===== hdl/tdoa_scale.sv =====
// Time scaling, rounding, saturation and reference subtraction stages.
`timescale 1ns / 1ps

module tdoa_scale import tdoa_pkg::*; #(
   parameter int POSITION_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [SCALE_WIDTH-1:0]        scale,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [POSITION_WIDTH:0]       in_root,
   input  logic [POSITION_WIDTH-1:0]     in_x,
   input  logic [POSITION_WIDTH-1:0]     in_y,
   input  logic                          in_ref,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [POSITION_WIDTH-1:0]     out_x,
   output logic [POSITION_WIDTH-1:0]     out_y,
   output logic [DIFF_WIDTH-1:0]         out_diff
);

   localparam int PW = POSITION_WIDTH;
   localparam int RW = PW + 1;
   localparam int QW = RW + SCALE_WIDTH;
   localparam int TW = QW + 1 - FRAC_SHIFT;
   localparam int EW = (TW > TIME_WIDTH) ? TW : TIME_WIDTH;
   localparam int NS = 3;

   logic [NS-1:0]          valid_ff;
   logic [NS:0]            ready;
   logic [PW-1:0]          x_ff   [NS];
   logic [PW-1:0]          y_ff   [NS];
   logic [NS-2:0]          ref_ff;

   logic [QW-1:0]          prod_ff;
   logic [QW:0]            rounded;
   logic [EW-1:0]          time_ext;
   logic [TIME_WIDTH-1:0]  time_in, time_ff;
   logic [TIME_WIDTH-1:0]  ref_time_ff;
   logic [DIFF_WIDTH-1:0]  diff_ff;

   always_comb begin
      ready[NS] = !out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      rounded  = (QW + 1)'(prod_ff) + ((QW + 1)'(1) << (FRAC_SHIFT - 1));
      time_ext = EW'(rounded[QW:FRAC_SHIFT]);
      time_in  = (time_ext > EW'(TIME_MAX)) ? TIME_MAX : time_ext[TIME_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ref_time_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
         if (ready[2] && valid_ff[1] && ref_ff[1]) ref_time_ff <= time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         prod_ff   <= QW'(in_root) * QW'(scale);
         x_ff[0]   <= in_x;
         y_ff[0]   <= in_y;
         ref_ff[0] <= in_ref;
      end
      if (ready[1]) begin
         time_ff   <= time_in;
         x_ff[1]   <= x_ff[0];
         y_ff[1]   <= y_ff[0];
         ref_ff[1] <= ref_ff[0];
      end
      if (ready[2]) begin
         diff_ff <= ref_ff[1] ? '0 : ({1'b0, time_ff} - {1'b0, ref_time_ff});
         x_ff[2] <= x_ff[1];
         y_ff[2] <= y_ff[1];
      end
   end

   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[NS-1];
   assign out_x     = x_ff[NS-1];
   assign out_y     = y_ff[NS-1];
   assign out_diff  = diff_ff;

endmodule

// ===== hdl/tdoa_range_difference.sv =====
// Top level: range difference of arrival, configuration registers and stage chain.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  receiver_x, receiver_y, is_reference
//   rsp      out        rsp_valid/rsp_stall  echo_x, echo_y, time_difference
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// One request per cycle sustained while rsp_stall is low, through
// 3 square stages, POSITION_WIDTH + 1 square root stages and 3 scale stages.
// Reset is synchronous: clears valid bits and reference time, reloads CSR defaults.
// Each stage holds while the next one is full and stalled; bubbles are squeezed out.
`timescale 1ns / 1ps

module tdoa_range_difference import tdoa_pkg::*; #(
   parameter int POSITION_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [((POSITION_WIDTH > SCALE_WIDTH) ? POSITION_WIDTH : SCALE_WIDTH)-1:0]
                                             csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [POSITION_WIDTH-1:0]  req_receiver_x,
   input  logic signed [POSITION_WIDTH-1:0]  req_receiver_y,
   input  logic                              req_is_reference,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [POSITION_WIDTH-1:0]  rsp_echo_x,
   output logic signed [POSITION_WIDTH-1:0]  rsp_echo_y,
   output logic signed [DIFF_WIDTH-1:0]      rsp_time_difference
);

   localparam int PW = POSITION_WIDTH;

   logic [PW-1:0]           emitter_x_ff, emitter_y_ff;
   logic                    units_in_feet_ff;
   logic [SCALE_WIDTH-1:0]  ns_per_meter_ff, ns_per_foot_ff, scale;

   logic                    sq_valid, sq_stall, sq_ref;
   logic [2*PW+1:0]         sq_sum;
   logic [PW-1:0]           sq_x, sq_y;
   logic                    rt_valid, rt_stall, rt_ref;
   logic [PW:0]             rt_root;
   logic [PW-1:0]           rt_x, rt_y;
   logic [PW-1:0]           out_x, out_y;
   logic [DIFF_WIDTH-1:0]   out_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emitter_x_ff     <= '0;
         emitter_y_ff     <= '0;
         units_in_feet_ff <= 1'b0;
         ns_per_meter_ff  <= NS_PER_METER_RESET;
         ns_per_foot_ff   <= NS_PER_FOOT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_EMITTER_X:     emitter_x_ff     <= csr_wdata[PW-1:0];
            CSR_EMITTER_Y:     emitter_y_ff     <= csr_wdata[PW-1:0];
            CSR_UNITS_IN_FEET: units_in_feet_ff <= csr_wdata[0];
            CSR_NS_PER_METER:  ns_per_meter_ff  <= csr_wdata[SCALE_WIDTH-1:0];
            CSR_NS_PER_FOOT:   ns_per_foot_ff   <= csr_wdata[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign scale = units_in_feet_ff ? ns_per_foot_ff : ns_per_meter_ff;

   tdoa_square #(.POSITION_WIDTH(PW)) u_square (
      .clock     (clock),
      .reset     (reset),
      .emitter_x (emitter_x_ff),
      .emitter_y (emitter_y_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_x      (req_receiver_x),
      .in_y      (req_receiver_y),
      .in_ref    (req_is_reference),
      .out_valid (sq_valid),
      .out_stall (sq_stall),
      .out_sum   (sq_sum),
      .out_x     (sq_x),
      .out_y     (sq_y),
      .out_ref   (sq_ref)
   );

   tdoa_sqrt #(.POSITION_WIDTH(PW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_stall  (sq_stall),
      .in_sum    (sq_sum),
      .in_x      (sq_x),
      .in_y      (sq_y),
      .in_ref    (sq_ref),
      .out_valid (rt_valid),
      .out_stall (rt_stall),
      .out_root  (rt_root),
      .out_x     (rt_x),
      .out_y     (rt_y),
      .out_ref   (rt_ref)
   );

   tdoa_scale #(.POSITION_WIDTH(PW)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .scale     (scale),
      .in_valid  (rt_valid),
      .in_stall  (rt_stall),
      .in_root   (rt_root),
      .in_x      (rt_x),
      .in_y      (rt_y),
      .in_ref    (rt_ref),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_diff  (out_diff)
   );

   assign rsp_echo_x          = $signed(out_x);
   assign rsp_echo_y          = $signed(out_y);
   assign rsp_time_difference = $signed(out_diff);

endmodule
